FILE: rtl/bbc_pkg.sv
// Shared types and constants for the blank band counter.
package bbc_pkg;

    // Field and register widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int LEVEL_W   = 8;
    localparam int COUNT_W   = 12;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register reset values
    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = CFG_W'(480);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_TAIL,
        ST_WRITEOUT
    } bbc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic pixel_accept;
        logic mem_clear;
        logic scan_read;
        logic step_index;
        logic restart_index;
        logic load_result;
    } bbc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_end;
        logic clear_last;
        logic scan_last;
        logic out_free;
    } bbc_status_t;

endpackage

FILE: rtl/bbc_ctrl.sv
// Controller state machine for the blank band counter.
module bbc_ctrl
    import bbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bbc_status_t status,
    output bbc_cmd_t    cmd
);

    bbc_state_t state_reg;
    bbc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.mem_clear = 1'b1;
                if (status.clear_last)
                begin
                    cmd.restart_index = 1'b1;
                    state_next        = ST_RUN;
                end
                else
                begin
                    cmd.step_index = 1'b1;
                end
            end
            ST_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.pixel_accept = 1'b1;
                    if (status.frame_end)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (status.scan_last)
                begin
                    cmd.restart_index = 1'b1;
                    state_next        = ST_TAIL;
                end
                else
                begin
                    cmd.step_index = 1'b1;
                end
            end
            ST_TAIL:
            begin
                // last column bit is being folded into the tally
                state_next = ST_WRITEOUT;
            end
            ST_WRITEOUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/bbc_datapath.sv
// Datapath: positions, row tally, column ink memory, column scan and result register.
module bbc_datapath
    import bbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_enable,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [LEVEL_W-1:0]   red_level,
    input  logic [LEVEL_W-1:0]   green_level,
    input  logic [LEVEL_W-1:0]   blue_level,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [COUNT_W-1:0]   row_bands,
    output logic [COUNT_W-1:0]   column_bands,
    input  bbc_cmd_t             cmd,
    output bbc_status_t          status
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (CFG_W > WID_W) ? CFG_W : WID_W;
    localparam int HCMP_W = (CFG_W > HGT_W) ? CFG_W : HGT_W;

    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    logic [COL_W-1:0]   col_pos_reg;
    logic [ROW_W-1:0]   row_pos_reg;
    logic               cur_ink_reg;
    logic               prev_ink_reg;
    logic [COUNT_W-1:0] row_tally_reg;
    logic [WID_W-1:0]   high_mark_reg;
    logic [COL_W-1:0]   index_reg;
    logic               rd_valid_reg;
    logic               rd_in_width_reg;
    logic               col_prev_reg;
    logic [COUNT_W-1:0] col_tally_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] row_bands_reg;
    logic [COUNT_W-1:0] column_bands_reg;

    logic               mem [MAX_WIDTH];
    logic               mem_q;

    logic [WCMP_W-1:0]  width_ext;
    logic [HCMP_W-1:0]  height_ext;
    logic [WID_W-1:0]   width;
    logic [HGT_W-1:0]   height;
    logic [WID_W-1:0]   col_plus;
    logic [HGT_W-1:0]   row_plus;
    logic [WID_W-1:0]   scan_len;
    logic               ink;
    logic               row_done;
    logic               frame_done;
    logic               mem_we;
    logic [COL_W-1:0]   mem_addr;
    logic               mem_wdata;

    // Size clamp: zero acts as one, oversize acts as the limit
    always_comb
    begin
        width_ext  = WCMP_W'(frame_width_reg);
        height_ext = HCMP_W'(frame_height_reg);
        priority if (width_ext == '0)
            width = WID_W'(1);
        else if (width_ext > WCMP_W'(MAX_WIDTH))
            width = WID_W'(MAX_WIDTH);
        else
            width = WID_W'(width_ext);
        priority if (height_ext == '0)
            height = HGT_W'(1);
        else if (height_ext > HCMP_W'(MAX_HEIGHT))
            height = HGT_W'(MAX_HEIGHT);
        else
            height = HGT_W'(height_ext);
    end

    // Pixel decode and row/frame end
    assign ink        = (red_level | green_level | blue_level) != '0;
    assign col_plus   = WID_W'(col_pos_reg) + WID_W'(1);
    assign row_plus   = HGT_W'(row_pos_reg) + HGT_W'(1);
    assign row_done   = col_plus >= width;
    assign frame_done = row_plus >= height;

    // Scan covers the active width and any column inked beyond it
    assign scan_len = (width > high_mark_reg) ? width : high_mark_reg;

    assign status.frame_end  = row_done && frame_done;
    assign status.clear_last = index_reg == COL_W'(MAX_WIDTH - 1);
    assign status.scan_last  = (WID_W'(index_reg) + WID_W'(1)) == scan_len;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Raster position and row band tally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            cur_ink_reg   <= 1'b0;
            prev_ink_reg  <= 1'b0;
            row_tally_reg <= '0;
            high_mark_reg <= '0;
        end
        else
        begin
            if (cmd.pixel_accept)
            begin
                if (ink && (col_plus > high_mark_reg))
                begin
                    high_mark_reg <= col_plus;
                end
                if (!row_done)
                begin
                    col_pos_reg <= COL_W'(col_plus);
                    cur_ink_reg <= cur_ink_reg | ink;
                end
                else
                begin
                    col_pos_reg <= '0;
                    cur_ink_reg <= 1'b0;
                    if ((cur_ink_reg || ink) && !prev_ink_reg)
                    begin
                        row_tally_reg <= row_tally_reg + COUNT_W'(1);
                    end
                    if (frame_done)
                    begin
                        row_pos_reg  <= '0;
                        prev_ink_reg <= 1'b0;
                    end
                    else
                    begin
                        row_pos_reg  <= ROW_W'(row_plus);
                        prev_ink_reg <= cur_ink_reg | ink;
                    end
                end
            end
            if (cmd.load_result)
            begin
                row_tally_reg <= '0;
                high_mark_reg <= '0;
            end
        end
    end

    // Shared sweep index for the clearing pass and the column scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else if (cmd.restart_index)
        begin
            index_reg <= '0;
        end
        else if (cmd.step_index)
        begin
            index_reg <= index_reg + COL_W'(1);
        end
    end

    // Column ink memory: pixels set bits, sweeps write zero behind the read
    assign mem_we    = (cmd.pixel_accept && ink) || cmd.mem_clear || cmd.scan_read;
    assign mem_addr  = cmd.pixel_accept ? col_pos_reg : index_reg;
    assign mem_wdata = cmd.pixel_accept;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.scan_read)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    // Column band count from the registered read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg    <= 1'b0;
            rd_in_width_reg <= 1'b0;
            col_prev_reg    <= 1'b0;
            col_tally_reg   <= '0;
        end
        else
        begin
            rd_valid_reg    <= cmd.scan_read;
            rd_in_width_reg <= WID_W'(index_reg) < width;
            if (rd_valid_reg && rd_in_width_reg)
            begin
                col_prev_reg <= mem_q;
                if (mem_q && !col_prev_reg)
                begin
                    col_tally_reg <= col_tally_reg + COUNT_W'(1);
                end
            end
            if (cmd.load_result)
            begin
                col_prev_reg  <= 1'b0;
                col_tally_reg <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            row_bands_reg    <= row_tally_reg;
            column_bands_reg <= col_tally_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_bands    = row_bands_reg;
    assign column_bands = column_bands_reg;

endmodule

FILE: rtl/blank_band_counter.sv
// Blank band counter top level: runs of non-blank rows and columns per RGB frame.
// Throughput: one pixel per cycle while a frame streams in.
// After the last pixel, the column scan reads max(width, furthest inked column) columns
// through the single port of the column ink memory; a tail state and the writeout state then load the result.
// A waiting result does not block the next frame until that frame's scan ends.
// Reset: a clearing pass sweeps all MAX_WIDTH entries of the ink memory; no pixel is taken then.
module blank_band_counter
    import bbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_enable,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LEVEL_W-1:0]   red_level,
    input  logic [LEVEL_W-1:0]   green_level,
    input  logic [LEVEL_W-1:0]   blue_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COUNT_W-1:0]   row_bands,
    output logic [COUNT_W-1:0]   column_bands
);

    bbc_cmd_t    cmd;
    bbc_status_t status;

    // Controller
    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    bbc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .red_level        (red_level),
        .green_level      (green_level),
        .blue_level       (blue_level),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .row_bands        (row_bands),
        .column_bands     (column_bands),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
